FILE: src/running_min_max_run_stats_assert.svh
// assertion macros for the running statistics block
`ifndef RUNNING_MIN_MAX_RUN_STATS_ASSERT_SVH
`define RUNNING_MIN_MAX_RUN_STATS_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge out of reset
`define RMMRS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition does not hold");

// antecedent at one edge implies consequent at the next edge
`define RMMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: expected next-cycle condition");

`else

`define RMMRS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RMMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/rmmrs_pkg.sv
`default_nettype none

package rmmrs_pkg;

  // data and counter widths
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        uvalue_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  localparam uvalue_t VALUE_SIGN = uvalue_t'(1) << (VALUE_WIDTH - 1);
  localparam count_t  COUNT_MAX  = '1;
  localparam count_t  COUNT_ONE  = count_t'(1);

  // counter increment that stops at all ones
  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_ONE;
  endfunction

  // less-than under signed or unsigned ordering
  function automatic logic val_less(input value_t a, input value_t b, input logic is_signed);
    uvalue_t ua;
    uvalue_t ub;
    ua = uvalue_t'(a);
    ub = uvalue_t'(b);
    if (is_signed) begin
      ua = ua ^ VALUE_SIGN;
      ub = ub ^ VALUE_SIGN;
    end
    val_less = (ua < ub);
  endfunction

endpackage

`default_nettype wire

FILE: src/running_min_max_run_stats.sv
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_value
// out       output     out_valid / out_ready  out_item_count .. out_longest_run
// cfg       input      cfg_wr_en (no wait)    cfg_wr_data (signed_compare)
//
// one item per clock sustained while out_ready stays high; an accepted item sits
// in the input register, and the statistics register takes its result once the
// result slot is free or being taken, and then holds it as the result.
// the statistics registers double as the result register, so they update only
// when the result slot is free or being taken; a stalled out_ready holds one
// item in the input register and then drops in_ready.
// synchronous active-low reset clears all statistics and sets signed compare.

module running_min_max_run_stats (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // input channel
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rmmrs_pkg::value_t in_value,
  // result channel
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rmmrs_pkg::count_t    out_item_count,
  output rmmrs_pkg::value_t    out_min_value,
  output rmmrs_pkg::count_t    out_min_index,
  output rmmrs_pkg::count_t    out_min_occurrences,
  output rmmrs_pkg::value_t    out_max_value,
  output rmmrs_pkg::count_t    out_max_index,
  output rmmrs_pkg::count_t    out_max_occurrences,
  output rmmrs_pkg::count_t    out_run_count,
  output rmmrs_pkg::count_t    out_longest_run,
  // configuration
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data
);
  import rmmrs_pkg::*;

  // control
  logic   signed_compare_r;
  logic   s1_valid_r;
  value_t s1_value_r;
  logic   out_valid_r;
  logic   upd_fire;

  // statistics state, also the result register
  count_t seen_r,      seen_nxt;
  value_t min_r,       min_nxt;
  count_t min_idx_r,   min_idx_nxt;
  count_t min_hits_r,  min_hits_nxt;
  value_t max_r,       max_nxt;
  count_t max_idx_r,   max_idx_nxt;
  count_t max_hits_r,  max_hits_nxt;
  value_t prev_r,      prev_nxt;
  count_t run_r,       run_nxt;
  count_t runs_r,      runs_nxt;
  count_t best_r,      best_nxt;

  logic first_item;
  logic take_min;
  logic take_max;

  // handshake: result slot free or draining lets the update stage move
  assign upd_fire = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || upd_fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_compare_r <= 1'b1;
    end else if (cfg_wr_en) begin
      signed_compare_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_value_r <= in_value;
    end
  end

  // next statistics for the item in the input register
  always_comb begin
    first_item = (seen_r == '0);
    take_min   = first_item || val_less(s1_value_r, min_r, signed_compare_r);
    take_max   = first_item || val_less(max_r, s1_value_r, signed_compare_r);

    // minimum tracking
    if (take_min) begin
      min_nxt      = s1_value_r;
      min_idx_nxt  = seen_r;
      min_hits_nxt = COUNT_ONE;
    end else begin
      min_nxt      = min_r;
      min_idx_nxt  = min_idx_r;
      min_hits_nxt = (s1_value_r == min_r) ? sat_inc(min_hits_r) : min_hits_r;
    end

    // maximum tracking
    if (take_max) begin
      max_nxt      = s1_value_r;
      max_idx_nxt  = seen_r;
      max_hits_nxt = COUNT_ONE;
    end else begin
      max_nxt      = max_r;
      max_idx_nxt  = max_idx_r;
      max_hits_nxt = (s1_value_r == max_r) ? sat_inc(max_hits_r) : max_hits_r;
    end

    // run tracking
    priority if (first_item) begin
      run_nxt  = COUNT_ONE;
      runs_nxt = COUNT_ONE;
    end else if (prev_r == s1_value_r) begin
      run_nxt  = sat_inc(run_r);
      runs_nxt = runs_r;
    end else begin
      run_nxt  = COUNT_ONE;
      runs_nxt = sat_inc(runs_r);
    end

    best_nxt = (run_nxt > best_r) ? run_nxt : best_r;
    seen_nxt = sat_inc(seen_r);
    prev_nxt = s1_value_r;
  end

  // statistics / result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      min_r       <= '0;
      min_idx_r   <= '0;
      min_hits_r  <= '0;
      max_r       <= '0;
      max_idx_r   <= '0;
      max_hits_r  <= '0;
      prev_r      <= '0;
      run_r       <= '0;
      runs_r      <= '0;
      best_r      <= '0;
    end else begin
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        seen_r      <= seen_nxt;
        min_r       <= min_nxt;
        min_idx_r   <= min_idx_nxt;
        min_hits_r  <= min_hits_nxt;
        max_r       <= max_nxt;
        max_idx_r   <= max_idx_nxt;
        max_hits_r  <= max_hits_nxt;
        prev_r      <= prev_nxt;
        run_r       <= run_nxt;
        runs_r      <= runs_nxt;
        best_r      <= best_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // outputs
  assign out_valid           = out_valid_r;
  assign out_item_count      = seen_r;
  assign out_min_value       = min_r;
  assign out_min_index       = min_idx_r;
  assign out_min_occurrences = min_hits_r;
  assign out_max_value       = max_r;
  assign out_max_index       = max_idx_r;
  assign out_max_occurrences = max_hits_r;
  assign out_run_count       = runs_r;
  assign out_longest_run     = best_r;

  // checks
  `include "running_min_max_run_stats_assert.svh"

  `RMMRS_ASSERT_ALWAYS(a_count_nonzero, clk, rst_n, !out_valid_r || (seen_r != '0))
  `RMMRS_ASSERT_ALWAYS(a_hits_nonzero, clk, rst_n,
    !out_valid_r || ((min_hits_r != '0) && (max_hits_r != '0)))
  `RMMRS_ASSERT_ALWAYS(a_runs_bounded, clk, rst_n,
    !out_valid_r || ((runs_r <= seen_r) && (best_r <= seen_r) && (best_r != '0)))
  `RMMRS_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && in_ready, s1_valid_r)

endmodule

`default_nettype wire

FILE: tb/running_min_max_run_stats_test.sv
`timescale 1ns / 1ps

module running_min_max_run_stats_test;
  import rmmrs_pkg::*;

  // one result item as the block reports it
  typedef struct packed {
    count_t item_count;
    value_t min_value;
    count_t min_index;
    count_t min_occurrences;
    value_t max_value;
    count_t max_index;
    count_t max_occurrences;
    count_t run_count;
    count_t longest_run;
  } stats_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed row: a value item or a compare-mode write (mode in bit 0)
  typedef struct packed {
    row_kind_t kind;
    uvalue_t   value;
    logic      typed;
    stats_t    want;
  } plan_row_t;

  localparam int PLAN_LEN    = 23;
  localparam int PHASE_ITEMS = 175;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP   = 40;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // signed compare after reset: first item sets everything
    '{ROW_ITEM, 32'h8000_0000, 1'b1,
      '{32'd1, 32'h8000_0000, 32'd0, 32'd1, 32'h8000_0000, 32'd0, 32'd1, 32'd1, 32'd1}},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b1,
      '{32'd2, 32'h8000_0000, 32'd0, 32'd1, 32'h7fff_ffff, 32'd1, 32'd1, 32'd2, 32'd1}},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'hffff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0001, 1'b0, '0},
    // unsigned compare, stored extremes kept
    '{ROW_CFG,  32'd0,         1'b0, '0},
    '{ROW_ITEM, 32'hffff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'hffff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'haaaa_aaaa, 1'b0, '0},
    '{ROW_ITEM, 32'h5555_5555, 1'b0, '0},
    // back to signed compare
    '{ROW_CFG,  32'd1,         1'b0, '0},
    '{ROW_ITEM, 32'h8000_0001, 1'b0, '0},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, '0},
    '{ROW_ITEM, 32'h1234_5678, 1'b0, '0}
  };

  logic   clk         = 1'b0;
  logic   rst_n       = 1'b0;
  logic   in_valid    = 1'b0;
  value_t in_value    = '0;
  logic   out_ready   = 1'b0;
  logic   cfg_wr_en   = 1'b0;
  logic   cfg_wr_data = 1'b0;

  logic   in_ready;
  logic   out_valid;
  count_t out_item_count;
  value_t out_min_value;
  count_t out_min_index;
  count_t out_min_occurrences;
  value_t out_max_value;
  count_t out_max_index;
  count_t out_max_occurrences;
  count_t out_run_count;
  count_t out_longest_run;

  // predictor state
  logic   cmp_signed = 1'b1;
  count_t seen_n     = '0;
  value_t lo_val     = '0;
  count_t lo_idx     = '0;
  count_t lo_hits    = '0;
  value_t hi_val     = '0;
  count_t hi_idx     = '0;
  count_t hi_hits    = '0;
  value_t last_val   = '0;
  count_t run_len    = '0;
  count_t runs_n     = '0;
  count_t best_len   = '0;

  stats_t pending_stats [$];
  logic   steady         = 1'b0;
  int     items_sent     = 0;
  int     directed_items = 0;
  int     results_seen   = 0;
  int     cfg_writes     = 0;
  int     mismatches     = 0;
  int     quiet_cycles   = 0;

  running_min_max_run_stats dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item_count      (out_item_count),
    .out_min_value       (out_min_value),
    .out_min_index       (out_min_index),
    .out_min_occurrences (out_min_occurrences),
    .out_max_value       (out_max_value),
    .out_max_index       (out_max_index),
    .out_max_occurrences (out_max_occurrences),
    .out_run_count       (out_run_count),
    .out_longest_run     (out_longest_run),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // counter step that holds at all ones
  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  // ordering under the current compare mode
  function automatic logic below(input value_t a, input value_t b);
    if (cmp_signed) begin
      return a < b;
    end
    return $unsigned(a) < $unsigned(b);
  endfunction

  // fold one value into the running statistics
  function automatic stats_t stats_step(input value_t v);
    logic   first;
    count_t idx;
    first = (seen_n == '0);
    idx   = seen_n;
    if (first || below(v, lo_val)) begin
      lo_val  = v;
      lo_idx  = idx;
      lo_hits = '0;
    end
    if (v == lo_val) begin
      lo_hits = bump(lo_hits);
    end
    if (first || below(hi_val, v)) begin
      hi_val  = v;
      hi_idx  = idx;
      hi_hits = '0;
    end
    if (v == hi_val) begin
      hi_hits = bump(hi_hits);
    end
    if (first) begin
      run_len = count_t'(1);
      runs_n  = count_t'(1);
    end else if (v == last_val) begin
      run_len = bump(run_len);
    end else begin
      run_len = count_t'(1);
      runs_n  = bump(runs_n);
    end
    if (run_len > best_len) begin
      best_len = run_len;
    end
    seen_n   = bump(seen_n);
    last_val = v;
    return '{item_count: seen_n, min_value: lo_val, min_index: lo_idx,
             min_occurrences: lo_hits, max_value: hi_val, max_index: hi_idx,
             max_occurrences: hi_hits, run_count: runs_n, longest_run: best_len};
  endfunction

  // random value, biased toward runs, small numbers and the current extremes
  function automatic value_t next_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return last_val;
    end
    if (r < 33) begin
      unique case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return VALUE_SIGN;
        default: return ~VALUE_SIGN;
      endcase
    end
    if (r < 53) begin
      return value_t'($urandom_range(0, 8)) - value_t'(4);
    end
    if (r < 63) begin
      return $urandom_range(0, 1) ? lo_val : hi_val;
    end
    return value_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h",
                                results_seen, name, got, want));
    end
  endtask

  // offer one value item, with a random gap unless in a steady stretch
  task automatic send_value(input value_t v, input logic typed, input stats_t typed_want);
    stats_t predicted;
    logic   took;
    if (!steady) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_value <= v;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    predicted = stats_step(v);
    pending_stats.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // compare-mode write, only once the block has drained
  task automatic set_compare(input logic mode);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cmp_signed = mode;
    cfg_writes++;
  endtask

  // result side stalls at random, except in a steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 34);
  end

  // compare each accepted result item with the oldest prediction
  always @(negedge clk) begin
    stats_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("result %0d with no item outstanding", results_seen));
      end else begin
        want = pending_stats.pop_front();
        check_field("item_count", out_item_count, want.item_count);
        check_field("min_value", out_min_value, want.min_value);
        check_field("min_index", out_min_index, want.min_index);
        check_field("min_occurrences", out_min_occurrences, want.min_occurrences);
        check_field("max_value", out_max_value, want.max_value);
        check_field("max_index", out_max_index, want.max_index);
        check_field("max_occurrences", out_max_occurrences, want.max_occurrences);
        check_field("run_count", out_run_count, want.run_count);
        check_field("longest_run", out_longest_run, want.longest_run);
      end
    end
  end

  // watchdog on cycles where no item moves on either channel
  always @(negedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_stats.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        set_compare(PLAN[i].value[0]);
      end else begin
        send_value(PLAN[i].value, PLAN[i].typed, PLAN[i].want);
      end
    end
    directed_items = items_sent;

    // random phases alternating compare mode, third phase without idling
    for (int p = 0; p < 4; p++) begin
      set_compare(p[0]);
      steady = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(next_value(), 1'b0, '0);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow the pipeline latency
    while (pending_stats.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("stream of %0d values (%0d directed) in both compare modes, %0d mode writes",
             items_sent, directed_items, cfg_writes);
    $display("%0d result items checked field by field, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
